### src/zmp_preview_pelvis_controller_unit_defines.svh
// Assertion macros for the checker file zpp_chk.sv.
`ifndef ZMP_PREVIEW_PELVIS_CONTROLLER_UNIT_DEFINES_SVH
`define ZMP_PREVIEW_PELVIS_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ZPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zpp check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ZPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zpp check failed");

`endif

### src/zpp_pkg.sv
`default_nettype none

package zpp_pkg;

    localparam int DEFAULT_PREVIEW_DEPTH = 256;
    localparam int IDX_W    = 8;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 32;
    localparam int SAT_BITS = 32;
    localparam int OPW      = 33;
    localparam int PROD_W   = 2 * OPW;
    localparam int ACC_W    = 64;
    localparam int UOP_W    = 4;

    localparam logic signed [ACC_W-1:0] SAT_MAX = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - 64'sd1;

    localparam logic [30:0]        RST_STEP_TIME  = 31'd524;
    localparam logic [30:0]        RST_HALF_T_SQ  = 31'd2;
    localparam logic [30:0]        RST_SIXTH_T_CU = 31'd0;
    localparam logic signed [31:0] RST_ZMP_COEF   = -32'sd4681;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [CFG_A_W-1:0] {
        REG_GAIN_INTEGRAL = 3'd0,
        REG_GAIN_POS      = 3'd1,
        REG_GAIN_VEL      = 3'd2,
        REG_GAIN_ACC      = 3'd3,
        REG_STEP_TIME     = 3'd4,
        REG_HALF_T_SQ     = 3'd5,
        REG_SIXTH_T_CU    = 3'd6,
        REG_ZMP_COEF      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [IDX_W-1:0]    index;
        logic signed [31:0]  gain_value;
        logic signed [31:0]  zmp_x;
        logic signed [31:0]  zmp_y;
        logic                last;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pelvis_x;
        logic signed [31:0] pelvis_y;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
    } out_word_t;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic load;
        logic add_en;
        logic neg;
    } mac_ctrl_t;

    typedef enum logic [2:0] {
        BASE_NONE, BASE_PACC, BASE_S0, BASE_S1, BASE_S2
    } base_sel_t;

    typedef enum logic [2:0] {
        OPA_GI, OPA_GP, OPA_GV, OPA_GA, OPA_ST, OPA_HTS, OPA_STC, OPA_ZC
    } opa_sel_t;

    typedef enum logic [2:0] {
        OPB_E, OPB_S0, OPB_S1, OPB_S2, OPB_U
    } opb_sel_t;

    typedef enum logic [2:0] {
        STO_NONE, STO_U, STO_N2, STO_N1, STO_N0, STO_C
    } store_sel_t;

    typedef struct packed {
        base_sel_t  base;
        opa_sel_t   a;
        opb_sel_t   b;
        logic       neg;
        store_sel_t store;
    } uop_t;

    localparam logic [UOP_W-1:0] UOP_LAST = 4'd10;

    // Per-axis step program: feedback, then acc, vel, pos, then model ZMP.
    function automatic uop_t uop_rom(input logic [UOP_W-1:0] idx);
        uop_t r;
        r = '{BASE_NONE, OPA_GI, OPB_E, 1'b0, STO_NONE};
        unique case (idx)
            4'd0:    r = '{BASE_PACC, OPA_GI,  OPB_E,  1'b1, STO_NONE};
            4'd1:    r = '{BASE_NONE, OPA_GP,  OPB_S0, 1'b1, STO_NONE};
            4'd2:    r = '{BASE_NONE, OPA_GV,  OPB_S1, 1'b1, STO_NONE};
            4'd3:    r = '{BASE_NONE, OPA_GA,  OPB_S2, 1'b1, STO_U};
            4'd4:    r = '{BASE_S2,   OPA_ST,  OPB_U,  1'b0, STO_N2};
            4'd5:    r = '{BASE_S1,   OPA_ST,  OPB_S2, 1'b0, STO_NONE};
            4'd6:    r = '{BASE_NONE, OPA_HTS, OPB_U,  1'b0, STO_N1};
            4'd7:    r = '{BASE_S0,   OPA_ST,  OPB_S1, 1'b0, STO_NONE};
            4'd8:    r = '{BASE_NONE, OPA_HTS, OPB_S2, 1'b0, STO_NONE};
            4'd9:    r = '{BASE_NONE, OPA_STC, OPB_U,  1'b0, STO_N0};
            4'd10:   r = '{BASE_S0,   OPA_ZC,  OPB_S2, 1'b0, STO_C};
            default: r = '{BASE_NONE, OPA_GI,  OPB_E,  1'b0, STO_NONE};
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q32.32 to Q16.16, floor, then saturate.
    function automatic logic signed [31:0] q16(input logic signed [ACC_W-1:0] v);
        return sat32(v >>> 16);
    endfunction

endpackage

`default_nettype wire

### src/zpp_gain_mem.sv
`default_nettype none

module zpp_gain_mem
    import zpp_pkg::*;
#(
    parameter int DEPTH = DEFAULT_PREVIEW_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire logic signed [31:0]  wdata,
    input  wire logic                re,
    input  wire logic [AW-1:0]       raddr,
    output logic signed [31:0]       rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/zpp_mac.sv
`default_nettype none

module zpp_mac
    import zpp_pkg::*;
(
    input  wire logic                     clk,
    input  wire mac_ctrl_t                ctrl,
    input  wire logic signed [OPW-1:0]    opa,
    input  wire logic signed [OPW-1:0]    opb,
    input  wire logic signed [ACC_W-1:0]  base,
    output logic signed [ACC_W-1:0]       sum
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] term;
    logic signed [ACC_W+2:0]  wide;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= opa * opb;
        end
        if (ctrl.load)
        begin
            acc_reg <= base;
        end else if (ctrl.add_en)
        begin
            acc_reg <= sum;
        end
    end

    // Saturate the sum at the 64-bit limits.
    always_comb
    begin
        term = ctrl.neg ? -prod_reg : prod_reg;
        wide = $signed({{3{acc_reg[ACC_W-1]}}, acc_reg}) + $signed({term[PROD_W-1], term});
        if (wide[ACC_W+2:ACC_W-1] != {4{wide[ACC_W+2]}})
        begin
            sum = wide[ACC_W+2] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else
        begin
            sum = wide[ACC_W-1:0];
        end
    end

endmodule

`default_nettype wire

### src/zmp_preview_pelvis_controller_unit.sv
// ZMP preview pelvis controller (cart-table model), Q16.16.
// Input channel in_valid/in_ready/in_data carries one word per op: load a
// preview gain entry, a reference ZMP sample of the preview window, or clear.
// Output channel out_valid/out_ready/out_data carries one word per window:
// the new pelvis position and velocity in x and y, saturated to 32 bits.
// Configuration: cfg_wen/cfg_addr/cfg_wdata write the gains and time
// constants; write them only while the block is idle.
// Sequence: load, clear and unused ops leave the block idle and ready.
// A sample reads the gain memory, then multiplies and accumulates for x
// and y on the one shared multiplier. After the last sample of a window
// each axis runs a setup step and eleven multiply-accumulate steps, then
// the result is posted and out_valid rises, unless the previous word
// is still unread.
// Reset clears the model state, sums and accumulators, and restores the
// register defaults; the gain table holds garbage until loaded.
// A stalled receiver holds the result word; the block still takes new
// words until the next window needs the output register.
`default_nettype none

module zmp_preview_pelvis_controller_unit
    import zpp_pkg::*;
#(
    parameter int PREVIEW_DEPTH = DEFAULT_PREVIEW_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire in_word_t            in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output out_word_t                out_data,
    input  wire logic                cfg_wen,
    input  wire logic [CFG_A_W-1:0]  cfg_addr,
    input  wire logic [CFG_D_W-1:0]  cfg_wdata
);

    localparam int AW = $clog2(PREVIEW_DEPTH);
    // one bit beyond the index so the table depth itself is representable
    localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SMUL = 7'b0000010,
        ST_SADD = 7'b0000100,
        ST_PREP = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_ADD  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [31:0] gi_reg, gp_reg, gv_reg, ga_reg, zc_reg;
    logic [30:0]        st_reg, hts_reg, stc_reg;

    // per-axis state, index 0 is x
    logic signed [31:0] s_reg [2][3];
    logic signed [31:0] osum_reg [2];
    logic signed [31:0] rsum_reg [2];
    logic signed [31:0] first_reg [2];
    logic signed [63:0] pacc_reg [2];

    // working registers
    logic               ax_reg;
    logic [UOP_W-1:0]   uop_reg;
    logic signed [31:0] zx_reg, zy_reg;
    logic               last_reg;
    logic signed [31:0] e_reg, u_reg, n1_reg, n2_reg;

    logic               out_valid_reg;
    out_word_t          out_data_reg;

    logic               accept;
    logic [IW-1:0]      idx_w;
    logic [AW-1:0]      addr;
    logic               in_range;
    logic signed [31:0] gain_rd;
    uop_t               cur;
    mac_ctrl_t          mac_ctrl;
    logic signed [OPW-1:0] opa, opb;
    logic signed [63:0] mac_base;
    logic signed [63:0] mac_sum;
    logic signed [31:0] q;
    logic               emit_go;

    function automatic logic signed [63:0] shl16(input logic signed [31:0] v);
        return {{16{v[31]}}, v, 16'h0000};
    endfunction

    function automatic logic signed [OPW-1:0] sx(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [OPW-1:0] zx31(input logic [30:0] v);
        return {2'b00, v};
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign idx_w    = IW'(in_data.index);
    assign addr     = idx_w[AW-1:0];
    assign in_range = (idx_w < IW'(PREVIEW_DEPTH));
    assign cur      = uop_rom(uop_reg);
    assign q        = q16(mac_sum);
    assign emit_go  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    zpp_gain_mem #(
        .DEPTH (PREVIEW_DEPTH),
        .AW    (AW)
    ) u_gain_mem (
        .clk   (clk),
        .we    (accept && in_data.op == OP_LOAD && in_range),
        .waddr (addr),
        .wdata (in_data.gain_value),
        .re    (accept && in_data.op == OP_SAMPLE),
        .raddr (addr),
        .rdata (gain_rd)
    );

    // Drive the shared multiply-accumulate: sample weighting or one step
    // of the axis program.
    always_comb
    begin
        mac_ctrl.mul_en = (state_reg == ST_SMUL) || (state_reg == ST_MUL);
        mac_ctrl.load   = (state_reg == ST_SMUL) ||
                          ((state_reg == ST_MUL) && (cur.base != BASE_NONE));
        mac_ctrl.add_en = (state_reg == ST_SADD) || (state_reg == ST_ADD);
        mac_ctrl.neg    = (state_reg == ST_ADD) && cur.neg;

        if (state_reg == ST_SMUL)
        begin
            opa = sx(gain_rd);
            opb = ax_reg ? sx(zy_reg) : sx(zx_reg);
        end else
        begin
            case (cur.a)
                OPA_GI:  opa = sx(gi_reg);
                OPA_GP:  opa = sx(gp_reg);
                OPA_GV:  opa = sx(gv_reg);
                OPA_GA:  opa = sx(ga_reg);
                OPA_ST:  opa = zx31(st_reg);
                OPA_HTS: opa = zx31(hts_reg);
                OPA_STC: opa = zx31(stc_reg);
                OPA_ZC:  opa = sx(zc_reg);
                default: opa = '0;
            endcase
            case (cur.b)
                OPB_E:   opb = sx(e_reg);
                OPB_S0:  opb = sx(s_reg[ax_reg][0]);
                OPB_S1:  opb = sx(s_reg[ax_reg][1]);
                OPB_S2:  opb = sx(s_reg[ax_reg][2]);
                OPB_U:   opb = sx(u_reg);
                default: opb = '0;
            endcase
        end

        if (state_reg == ST_SMUL)
        begin
            mac_base = pacc_reg[ax_reg];
        end else
        begin
            case (cur.base)
                BASE_PACC: mac_base = pacc_reg[ax_reg];
                BASE_S0:   mac_base = shl16(s_reg[ax_reg][0]);
                BASE_S1:   mac_base = shl16(s_reg[ax_reg][1]);
                BASE_S2:   mac_base = shl16(s_reg[ax_reg][2]);
                default:   mac_base = '0;
            endcase
        end
    end

    zpp_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .opa  (opa),
        .opb  (opb),
        .base (mac_base),
        .sum  (mac_sum)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gi_reg  <= '0;
            gp_reg  <= '0;
            gv_reg  <= '0;
            ga_reg  <= '0;
            st_reg  <= RST_STEP_TIME;
            hts_reg <= RST_HALF_T_SQ;
            stc_reg <= RST_SIXTH_T_CU;
            zc_reg  <= RST_ZMP_COEF;
        end else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_GAIN_INTEGRAL: gi_reg  <= cfg_wdata;
                REG_GAIN_POS:      gp_reg  <= cfg_wdata;
                REG_GAIN_VEL:      gv_reg  <= cfg_wdata;
                REG_GAIN_ACC:      ga_reg  <= cfg_wdata;
                REG_STEP_TIME:     st_reg  <= cfg_wdata[30:0];
                REG_HALF_T_SQ:     hts_reg <= cfg_wdata[30:0];
                REG_SIXTH_T_CU:    stc_reg <= cfg_wdata[30:0];
                REG_ZMP_COEF:      zc_reg  <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // sequencer and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ax_reg    <= 1'b0;
            uop_reg   <= '0;
            for (int a = 0; a < 2; a++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s_reg[a][k] <= '0;
                end
                osum_reg[a]  <= '0;
                rsum_reg[a]  <= '0;
                first_reg[a] <= '0;
                pacc_reg[a]  <= '0;
            end
        end else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_data.op)
                            OP_SAMPLE:
                            begin
                                zx_reg   <= in_data.zmp_x;
                                zy_reg   <= in_data.zmp_y;
                                last_reg <= in_data.last;
                                ax_reg   <= 1'b0;
                                if (in_data.index == '0)
                                begin
                                    first_reg[0] <= in_data.zmp_x;
                                    first_reg[1] <= in_data.zmp_y;
                                end
                                // an out-of-table sample adds nothing
                                if (in_range)
                                begin
                                    state_reg <= ST_SMUL;
                                end else if (in_data.last)
                                begin
                                    state_reg <= ST_PREP;
                                end
                            end
                            OP_CLEAR:
                            begin
                                for (int a = 0; a < 2; a++)
                                begin
                                    for (int k = 0; k < 3; k++)
                                    begin
                                        s_reg[a][k] <= '0;
                                    end
                                    osum_reg[a]  <= '0;
                                    rsum_reg[a]  <= '0;
                                    first_reg[a] <= '0;
                                    pacc_reg[a]  <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SMUL:
                begin
                    state_reg <= ST_SADD;
                end
                ST_SADD:
                begin
                    pacc_reg[ax_reg] <= mac_sum;
                    if (!ax_reg)
                    begin
                        ax_reg    <= 1'b1;
                        state_reg <= ST_SMUL;
                    end else
                    begin
                        ax_reg    <= 1'b0;
                        state_reg <= last_reg ? ST_PREP : ST_IDLE;
                    end
                end
                ST_PREP:
                begin
                    // latch the saturated tracking error for this axis
                    e_reg     <= sat32(64'(osum_reg[ax_reg]) - 64'(rsum_reg[ax_reg]));
                    uop_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    case (cur.store)
                        STO_U:  u_reg  <= q;
                        STO_N2: n2_reg <= q;
                        STO_N1: n1_reg <= q;
                        STO_N0:
                        begin
                            // commit the new state together
                            s_reg[ax_reg][0] <= q;
                            s_reg[ax_reg][1] <= n1_reg;
                            s_reg[ax_reg][2] <= n2_reg;
                        end
                        STO_C:
                        begin
                            osum_reg[ax_reg]  <= sat32(64'(osum_reg[ax_reg]) + 64'(q));
                            rsum_reg[ax_reg]  <= sat32(64'(rsum_reg[ax_reg]) +
                                                       64'(first_reg[ax_reg]));
                            pacc_reg[ax_reg]  <= '0;
                            first_reg[ax_reg] <= '0;
                        end
                        default: ;
                    endcase
                    if (uop_reg == UOP_LAST)
                    begin
                        if (!ax_reg)
                        begin
                            ax_reg    <= 1'b1;
                            state_reg <= ST_PREP;
                        end else
                        begin
                            ax_reg    <= 1'b0;
                            state_reg <= ST_EMIT;
                        end
                    end else
                    begin
                        uop_reg   <= uop_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_EMIT:
                begin
                    // hold here while the previous word is still unread
                    if (emit_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_data_reg.pelvis_x   <= s_reg[0][0];
            out_data_reg.pelvis_y   <= s_reg[1][0];
            out_data_reg.velocity_x <= s_reg[0][1];
            out_data_reg.velocity_y <= s_reg[1][1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### src/zpp_chk.sv
`default_nettype none
`include "zmp_preview_pelvis_controller_unit_defines.svh"

module zpp_chk
    import zpp_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire in_word_t            in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire out_word_t           out_data
);

    // a stalled result word holds
    `ZPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // the last sample of a window always keeps the engine busy
    `ZPP_ASSERT_NEXT(a_busy_after_last,
        in_valid && in_ready && in_data.op == OP_SAMPLE && in_data.last, !in_ready)

    // loads, clears and unused ops leave the engine ready in the following cycle
    `ZPP_ASSERT_NEXT(a_single_cycle_ops,
        in_valid && in_ready && in_data.op != OP_SAMPLE, in_ready)

    // a new result is only posted from the busy engine
    `ZPP_ASSERT_NOW(a_result_from_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind zmp_preview_pelvis_controller_unit zpp_chk u_zpp_chk (.*);

`default_nettype wire
